### hdl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// Each use expects a clock named clk and an active-low reset named rst_n
// in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is held.
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset, for reset behaviour itself.
`define TTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and helpers of the task table scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // Number of task slots in the priority table.
  localparam int unsigned TASK_SLOTS = 64;

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    CMD_CREATE   = 1'b0,
    CMD_SCHEDULE = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_RR   = 1'b0,
    MODE_PRIO = 1'b1
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_TASKS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_PUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic create;      // store a new task, or report a full table
    logic sched_rr;    // advance the current task round-robin
    logic no_tasks;    // answer with the no-tasks status
    logic pick_start;  // read the current task's priority
    logic pick_fetch;  // capture it and start the scan at slot 0
    logic pick_step;   // move the scan on by one slot
    logic pick_hit;    // answer with the slot under compare
    logic pick_miss;   // answer with the current task
    logic push;        // move the result into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  cnt_zero;
    mode_t mode;
    logic  scan_hit;
    logic  scan_last;
    logic  out_free;
  } stat_t;

  // Low IDX_W bits of a slot number, zero-extended where slots are fewer.
  function automatic logic [IDX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, slot};
    return wide[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/tts_in_if.sv
// ----------------------------------------------------------------------------
// tts_in_if
// Request channel: command and priority of a new task.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [tts_pkg::PRIO_W-1:0]     task_priority;

  modport source (output valid, output cmd, output task_priority, input ready);
  modport sink   (input valid, input cmd, input task_priority, output ready);
endinterface

`default_nettype wire

### hdl/tts_out_if.sv
// ----------------------------------------------------------------------------
// tts_out_if
// Result channel: status and slot index.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_out_if;
  logic                           valid;
  logic                           ready;
  logic [tts_pkg::STAT_W-1:0]     status;
  logic [tts_pkg::IDX_W-1:0]      task_index;

  modport source (output valid, output status, output task_index, input ready);
  modport sink   (input valid, input status, input task_index, output ready);
endinterface

`default_nettype wire

### hdl/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/tts_datapath.sv
// ----------------------------------------------------------------------------
// tts_datapath
// Task count, current task, priority table, scan compare and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  input  wire logic [tts_pkg::PRIO_W-1:0]   new_priority,
  input  wire tts_pkg::ctl_t                ctl,
  output tts_pkg::stat_t                    stat,
  tts_out_if.source                         out_chan
);

  logic [tts_pkg::CNT_W-1:0]  task_count_r,   task_count_nxt;
  logic [tts_pkg::SLOT_W-1:0] current_task_r, current_task_nxt;
  tts_pkg::mode_t             policy_mode_r;
  logic [tts_pkg::PRIO_W-1:0] cur_prio_r;
  logic [tts_pkg::SLOT_W-1:0] cmp_idx_r,      cmp_idx_nxt;
  tts_pkg::status_t           res_status_r,   res_status_nxt;
  logic [tts_pkg::SLOT_W-1:0] res_slot_r,     res_slot_nxt;
  logic                       out_valid_r;
  tts_pkg::status_t           out_status_r;
  logic [tts_pkg::IDX_W-1:0]  out_index_r;

  logic                       table_full;
  logic [tts_pkg::CNT_W-1:0]  rr_next;
  logic [tts_pkg::CNT_W-1:0]  cmp_next;
  logic [tts_pkg::SLOT_W-1:0] rd_addr;
  logic [tts_pkg::PRIO_W-1:0] rd_data;
  logic                       wr_en;

  tts_ram #(
    .WIDTH (tts_pkg::PRIO_W),
    .DEPTH (tts_pkg::TASK_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (task_count_r[tts_pkg::SLOT_W-1:0]),
    .wr_data (new_priority),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign table_full = (task_count_r == tts_pkg::CNT_W'(tts_pkg::TASK_SLOTS));
  assign wr_en      = ctl.create && !table_full;
  assign rr_next    = tts_pkg::CNT_W'(current_task_r) + tts_pkg::CNT_W'(1);
  assign cmp_next   = tts_pkg::CNT_W'(cmp_idx_r) + tts_pkg::CNT_W'(1);

  // Read port: current task first, then slot 0, then, one slot a cycle, the slot after the one under compare.
  always_comb begin
    priority if (ctl.pick_start) begin
      rd_addr = current_task_r;
    end else if (ctl.pick_fetch) begin
      rd_addr = '0;
    end else begin
      rd_addr = cmp_next[tts_pkg::SLOT_W-1:0];
    end
  end

  assign stat.cnt_zero  = (task_count_r == '0);
  assign stat.mode      = policy_mode_r;
  assign stat.scan_hit  = (cmp_idx_r != current_task_r) && (rd_data <= cur_prio_r);
  assign stat.scan_last = (cmp_next >= task_count_r);
  assign stat.out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    task_count_nxt   = task_count_r;
    current_task_nxt = current_task_r;
    cmp_idx_nxt      = cmp_idx_r;
    res_status_nxt   = res_status_r;
    res_slot_nxt     = res_slot_r;
    if (ctl.create) begin
      if (table_full) begin
        res_status_nxt = tts_pkg::ST_FULL;
        res_slot_nxt   = '0;
      end else begin
        res_status_nxt = tts_pkg::ST_OK;
        res_slot_nxt   = task_count_r[tts_pkg::SLOT_W-1:0];
        task_count_nxt = task_count_r + tts_pkg::CNT_W'(1);
      end
    end
    if (ctl.sched_rr) begin
      current_task_nxt = (rr_next >= task_count_r) ? '0 : rr_next[tts_pkg::SLOT_W-1:0];
      res_status_nxt   = tts_pkg::ST_OK;
      res_slot_nxt     = current_task_nxt;
    end
    if (ctl.no_tasks) begin
      res_status_nxt = tts_pkg::ST_NO_TASKS;
      res_slot_nxt   = '0;
    end
    if (ctl.pick_fetch) begin
      cmp_idx_nxt = '0;
    end
    if (ctl.pick_step) begin
      cmp_idx_nxt = cmp_next[tts_pkg::SLOT_W-1:0];
    end
    if (ctl.pick_hit) begin
      res_status_nxt = tts_pkg::ST_OK;
      res_slot_nxt   = cmp_idx_r;
    end
    if (ctl.pick_miss) begin
      res_status_nxt = tts_pkg::ST_OK;
      res_slot_nxt   = current_task_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r   <= '0;
      current_task_r <= '0;
      policy_mode_r  <= tts_pkg::MODE_RR;
      out_valid_r    <= 1'b0;
    end else begin
      task_count_r   <= task_count_nxt;
      current_task_r <= current_task_nxt;
      if (cfg_we) begin
        policy_mode_r <= tts_pkg::mode_t'(cfg_wdata);
      end
      if (ctl.push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (ctl.pick_fetch) begin
      cur_prio_r <= rd_data;
    end
    if (ctl.push) begin
      out_status_r <= res_status_r;
      out_index_r  <= tts_pkg::slot_to_index(res_slot_r);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.task_index = out_index_r;

endmodule

`default_nettype wire

### hdl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer: takes a request, runs the priority scan, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  tts_in_if.sink               in_chan,
  input  wire tts_pkg::stat_t  stat,
  output tts_pkg::ctl_t        ctl,
  output tts_pkg::state_t      state
);

  tts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    in_chan.ready = 1'b0;
    unique case (state_r)
      tts_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          priority if (in_chan.cmd == tts_pkg::CMD_CREATE) begin
            ctl.create = 1'b1;
            state_nxt  = tts_pkg::S_PUSH;
          end else if (stat.cnt_zero) begin
            ctl.no_tasks = 1'b1;
            state_nxt    = tts_pkg::S_PUSH;
          end else if (stat.mode == tts_pkg::MODE_RR) begin
            ctl.sched_rr = 1'b1;
            state_nxt    = tts_pkg::S_PUSH;
          end else begin
            ctl.pick_start = 1'b1;
            state_nxt      = tts_pkg::S_FETCH;
          end
        end
      end
      tts_pkg::S_FETCH: begin
        ctl.pick_fetch = 1'b1;
        state_nxt      = tts_pkg::S_SCAN;
      end
      tts_pkg::S_SCAN: begin
        priority if (stat.scan_hit) begin
          ctl.pick_hit = 1'b1;
          state_nxt    = tts_pkg::S_PUSH;
        end else if (stat.scan_last) begin
          ctl.pick_miss = 1'b1;
          state_nxt     = tts_pkg::S_PUSH;
        end else begin
          ctl.pick_step = 1'b1;
        end
      end
      tts_pkg::S_PUSH: begin
        if (stat.out_free) begin
          ctl.push  = 1'b1;
          state_nxt = tts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tts_pkg::S_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

`default_nettype wire

### hdl/task_table_scheduler.sv
// ----------------------------------------------------------------------------
// task_table_scheduler
// Task priority table with round-robin and priority-ordered task selection.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : valid/ready request channel carrying cmd and task_priority.
//              A create request stores the priority in the next free slot;
//              a schedule request asks for the next task to run.
//   out_chan : valid/ready result channel carrying status and task_index,
//              exactly one result per request, in request order.
//   cfg_we / cfg_wdata : policy_mode register, 0 round-robin, 1 priority;
//              write it only while no request is in flight.
//   Sequence : create, round-robin and no-task requests go from idle to the
//              push state; a priority pick fetches the current task's priority,
//              then scans from slot 0, n slots (1..count), then pushes.
//   Throughput: a new request is taken only back in idle, after the last result
//              is pushed to the output register; the scan reads one table entry
//              a cycle through the single RAM read port.
//   Reset    : rst_n (synchronous) empties the table count, zeroes the current
//              task, selects round-robin and drops any pending result.
//   Stall    : a finished result waits in the output register; the block still
//              takes one further request and holds its result until the
//              output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module task_table_scheduler (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tts_in_if.sink      in_chan,
  tts_out_if.source   out_chan,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata
);

  tts_pkg::ctl_t   ctl;
  tts_pkg::stat_t  stat;
  tts_pkg::state_t state;
  logic            req_taken;
  logic            seq_busy;

  // Sequencer: owns the request handshake and steps the datapath.
  tts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .stat    (stat),
    .ctl     (ctl),
    .state   (state)
  );

  // Datapath: table RAM, counters, scan compare and output register.
  tts_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .new_priority (in_chan.task_priority),
    .ctl          (ctl),
    .stat         (stat),
    .out_chan     (out_chan)
  );

  assign req_taken = in_chan.valid && in_chan.ready;
  assign seq_busy  = (state != tts_pkg::S_IDLE) && !in_chan.ready;

  // Hold no result out of reset.
  `TTS_ASSERT_RST(a_reset_drops_result, !rst_n |=> !out_chan.valid, "result valid after reset")

  // Advance the sequencer off idle after every accepted request.
  `TTS_ASSERT(a_one_in_flight, req_taken |=> seq_busy, "second request taken while busy")

  // Drive at most one datapath command per cycle.
  `TTS_ASSERT(a_single_cmd, $onehot0(ctl), "conflicting datapath commands")

  // Load the output register only when it is free.
  `TTS_ASSERT(a_push_free, ctl.push |-> stat.out_free, "result overwritten before taken")

endmodule

`default_nettype wire
